[hdl/seq_pkg.sv]
// Shared types, codes and the key compare for the sorted event queue.
// Used by seq_cell and sorted_event_queue; depends on nothing else.
package seq_pkg;

  localparam int SEQ_CAPACITY = 64;

  localparam int TIME_W = 32;
  localparam int PRIO_W = 8;
  localparam int SERV_W = 32;
  localparam int OCC_W  = 7;
  localparam int STAT_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] event_time;
    logic [PRIO_W-1:0] priority_req;
    logic [SERV_W-1:0] service_time;
  } entry_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] event_time;
    logic [PRIO_W-1:0] priority_req;
    logic [SERV_W-1:0] service_time;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] head_time;
    logic [PRIO_W-1:0] head_priority;
    logic [SERV_W-1:0] head_service;
    logic [OCC_W-1:0]  occupancy;
  } out_rsp_t;

  // chain-wide control, same for every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  // true when key of a sorts strictly before key of b
  function automatic logic key_before(entry_t a, entry_t b);
    logic t_lt;
    logic t_eq;
    t_lt = a.event_time < b.event_time;
    t_eq = a.event_time == b.event_time;
    return t_lt || (t_eq && (a.priority_req < b.priority_req));
  endfunction

endpackage

[hdl/seq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the new key
// and shifts with its neighbors. Depends on seq_pkg.
module seq_cell
  import seq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  logic      occupied,
  input  entry_t    left_entry,
  input  logic      left_ge,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      ge
);

  entry_t entry_r;
  entry_t entry_nxt;

  // empty slots always sit behind the new key
  assign ge = !occupied || !key_before(entry_r, new_entry);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (left_ge) begin
        entry_nxt = left_entry;
      end else if (ge) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[hdl/sorted_event_queue.sv]
// Top level of the sorted event queue: a chain of seq_cell slots, the fill
// count and the result register. Depends on seq_pkg and seq_cell.
//
// Bounded future-event list kept in ascending (event_time, priority_req)
// order; a new entry goes ahead of stored entries with an equal key. Each
// request is either an insert or a pop of the head and gives exactly one
// result in a register after acceptance, so a request can be accepted every
// cycle while the result side keeps up. All CAPACITY slots compare against
// the new key and shift by one place in the same cycle; the slowest path is
// one 40-bit key compare per slot plus the fan-out of the new key to every
// slot. No clearing pass is needed after reset: slots at or above the fill
// count are never read.
module sorted_event_queue
  import seq_pkg::*;
#(
  parameter int CAPACITY = SEQ_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_rsp_t         out_data_r;
  out_rsp_t         out_data_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  entry_t    new_entry;

  entry_t entry_w [CAPACITY];
  logic   ge_w    [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign empty    = count_r == '0;

  assign ctl.insert = accept && (in_data.kind == KIND_INSERT) && !full;
  assign ctl.pop    = accept && (in_data.kind == KIND_POP) && !empty;

  assign new_entry.event_time   = in_data.event_time;
  assign new_entry.priority_req = in_data.priority_req;
  assign new_entry.service_time = in_data.service_time;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    entry_t right_e;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_g = ge_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end

    seq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .occupied    (CNT_W'(i) < count_r),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .ge          (ge_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (in_data.kind == KIND_INSERT) begin
        out_data_nxt.status = full ? ST_FULL : ST_DONE;
      end else if (empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.status        = ST_DONE;
        out_data_nxt.head_time     = entry_w[0].event_time;
        out_data_nxt.head_priority = entry_w[0].priority_req;
        out_data_nxt.head_service  = entry_w[0].service_time;
      end
      out_data_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_FULL)) |->
      (out_data_r.occupancy == OCC_W'(CAPACITY)))
    else $error("full reject with wrong occupancy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_EMPTY)) |->
      (out_data_r.occupancy == '0 && out_data_r.head_time == '0))
    else $error("empty pop result not cleared");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not bump fill count");
`endif

endmodule
